// File: src/alcl_pkg.sv
// ----------------------------------------------------------------------------
// alcl_pkg
// Shared types, character codes and response texts for the AT response line
// classifier.
// ----------------------------------------------------------------------------
package alcl_pkg;

	typedef enum logic [1:0] {
		CLS_LINE   = 2'd0,
		CLS_OK     = 2'd1,
		CLS_ERROR  = 2'd2,
		CLS_PROMPT = 2'd3
	} line_class_t;

	typedef struct packed {
		logic store;
		logic clear;
	} scan_ctl_t;

	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PROMPT = 8'h3E;

	localparam int OK_LEN   = 2;
	localparam int ERR_LEN  = 5;
	localparam int CODE_LEN = 10;

	localparam logic [0:OK_LEN-1][7:0]   OK_TXT  = "OK";
	localparam logic [0:ERR_LEN-1][7:0]  ERR_TXT = "ERROR";
	localparam logic [0:CODE_LEN-1][7:0] CME_TXT = "+CME ERROR";
	localparam logic [0:CODE_LEN-1][7:0] CMS_TXT = "+CMS ERROR";

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

endpackage

// File: src/at_response_line_classifier_top.sv
// ----------------------------------------------------------------------------
// at_response_line_classifier_top
// Collects modem bytes into a line store and emits trimmed, classified lines.
// ----------------------------------------------------------------------------
// While idle the block takes one byte per cycle; each data byte (not CR, LF,
// a prompt or an overflowing byte) is written to the line store RAM and
// tracked for trimming and class in the same cycle. A newline ending a
// non-blank line starts emission: every byte of the trimmed line is read back
// through the single RAM read port and loaded into the output register, and
// in_ready stays low until the last byte is loaded. A prompt is emitted as a
// single byte. The store needs no clearing pass after reset.
module at_response_line_classifier_top import alcl_pkg::*; #(
	parameter int LINE_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  line_class,
	output logic [7:0]  line_char,
	output logic        last_char,
	output logic [31:0] lines_seen,
	output logic [31:0] overflows_seen
);

	localparam int LEN_W = $clog2(LINE_BYTES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_CAP,
		ST_PROMPT
	} state_t;

	state_t           state_q;
	logic             enable_q;
	logic [31:0]      lines_q;
	logic [31:0]      overflow_q;
	logic [LEN_W-1:0] rd_ptr_q;
	logic [LEN_W-1:0] stop_q;
	line_class_t      cls_q;
	logic             out_valid_q;
	logic [1:0]       class_q;
	logic [7:0]       char_q;
	logic             last_q;
	logic [31:0]      seen_q;
	logic [31:0]      ovf_q;

	scan_ctl_t        scan_ctl;
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] first;
	logic [LEN_W-1:0] stop;
	logic             nonblank;
	line_class_t      cls;
	logic [7:0]       rd_data;
	logic             take;
	logic             is_cr;
	logic             is_lf;
	logic             is_pr;
	logic             full;
	logic             slot_free;
	logic             out_load;
	logic             rd_last;

	assign in_ready  = (state_q == ST_IDLE);
	assign take      = in_valid && in_ready && enable_q;
	assign is_cr     = (rx_byte == CH_CR);
	assign is_lf     = (rx_byte == CH_LF);
	assign is_pr     = (rx_byte == CH_PROMPT) && !nonblank;
	assign full      = (len == LEN_W'(LINE_BYTES - 1));
	assign slot_free = !out_valid_q || out_ready;
	assign out_load  = slot_free && ((state_q == ST_CAP) || (state_q == ST_PROMPT));
	assign rd_last   = (rd_ptr_q == stop_q - LEN_W'(1));

	always_comb begin
		scan_ctl.store = take && !is_cr && !is_lf && !is_pr && !full;
		scan_ctl.clear = (take && !is_cr && (is_lf || is_pr || full))
			|| (cfg_wr_en && cfg_wr_data && !enable_q);
	end

	alcl_scan #(
		.LINE_BYTES(LINE_BYTES)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.byte_in  (rx_byte),
		.len      (len),
		.first    (first),
		.stop     (stop),
		.nonblank (nonblank),
		.cls      (cls)
	);

	alcl_ram #(
		.WIDTH(8),
		.DEPTH(LINE_BYTES)
	) u_store (
		.clk     (clk),
		.wr_en   (scan_ctl.store),
		.wr_addr (len),
		.wr_data (rx_byte),
		.rd_en   (state_q == ST_RD),
		.rd_addr (rd_ptr_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			enable_q    <= 1'b0;
			lines_q     <= '0;
			overflow_q  <= '0;
			out_valid_q <= 1'b0;
			rd_ptr_q    <= '0;
			stop_q      <= '0;
			cls_q       <= CLS_LINE;
			class_q     <= '0;
			char_q      <= '0;
			last_q      <= 1'b0;
			seen_q      <= '0;
			ovf_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				enable_q <= cfg_wr_data;
			end
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take && !is_cr) begin
						if (is_lf) begin
							if (nonblank) begin
								lines_q  <= lines_q + 32'd1;
								rd_ptr_q <= first;
								stop_q   <= stop;
								cls_q    <= cls;
								state_q  <= ST_RD;
							end
						end else if (is_pr) begin
							lines_q <= lines_q + 32'd1;
							state_q <= ST_PROMPT;
						end else if (full) begin
							overflow_q <= overflow_q + 32'd1;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_CAP;
				end
				ST_CAP: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						class_q     <= cls_q;
						char_q      <= rd_data;
						last_q      <= rd_last;
						seen_q      <= lines_q;
						ovf_q       <= overflow_q;
						rd_ptr_q    <= rd_ptr_q + LEN_W'(1);
						state_q     <= rd_last ? ST_IDLE : ST_RD;
					end
				end
				ST_PROMPT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						class_q     <= CLS_PROMPT;
						char_q      <= CH_PROMPT;
						last_q      <= 1'b1;
						seen_q      <= lines_q;
						ovf_q       <= overflow_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign line_class     = class_q;
	assign line_char      = char_q;
	assign last_char      = last_q;
	assign lines_seen     = seen_q;
	assign overflows_seen = ovf_q;

endmodule

// File: src/alcl_ram.sv
// ----------------------------------------------------------------------------
// alcl_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module alcl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/alcl_scan.sv
// ----------------------------------------------------------------------------
// alcl_scan
// Line tracker: fill length, trimmed run bounds and running prefix matches
// against the known response texts, giving the class of the trimmed line.
// ----------------------------------------------------------------------------
module alcl_scan import alcl_pkg::*; #(
	parameter int LINE_BYTES = 64,
	localparam int LEN_W = $clog2(LINE_BYTES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  scan_ctl_t        ctl,
	input  logic [7:0]       byte_in,
	output logic [LEN_W-1:0] len,
	output logic [LEN_W-1:0] first,
	output logic [LEN_W-1:0] stop,
	output logic             nonblank,
	output line_class_t      cls
);

	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] first_q;
	logic [LEN_W-1:0] stop_q;
	logic             nonblank_q;
	logic [3:0]       off_q;
	logic             ok_m_q;
	logic             err_m_q;
	logic             cme_m_q;
	logic             cms_m_q;
	logic             pr_m_q;
	logic             in_run;
	logic [LEN_W-1:0] n;
	logic [6:0]       n7;

	assign in_run = nonblank_q || !is_blank(byte_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			nonblank_q <= 1'b0;
			off_q      <= '0;
			ok_m_q     <= 1'b1;
			err_m_q    <= 1'b1;
			cme_m_q    <= 1'b1;
			cms_m_q    <= 1'b1;
			pr_m_q     <= 1'b1;
		end else if (ctl.clear) begin
			len_q      <= '0;
			nonblank_q <= 1'b0;
			off_q      <= '0;
			ok_m_q     <= 1'b1;
			err_m_q    <= 1'b1;
			cme_m_q    <= 1'b1;
			cms_m_q    <= 1'b1;
			pr_m_q     <= 1'b1;
		end else if (ctl.store) begin
			len_q <= len_q + LEN_W'(1);
			if (!is_blank(byte_in)) begin
				nonblank_q <= 1'b1;
			end
			if (in_run) begin
				if (off_q < 4'(CODE_LEN)) begin
					off_q <= off_q + 4'd1;
				end
				if (off_q < 4'(OK_LEN)) begin
					ok_m_q <= ok_m_q & (byte_in == OK_TXT[off_q[0]]);
				end
				if (off_q < 4'(ERR_LEN)) begin
					err_m_q <= err_m_q & (byte_in == ERR_TXT[off_q[2:0]]);
				end
				if (off_q < 4'(CODE_LEN)) begin
					cme_m_q <= cme_m_q & (byte_in == CME_TXT[off_q]);
					cms_m_q <= cms_m_q & (byte_in == CMS_TXT[off_q]);
				end
				if (off_q == 4'd0) begin
					pr_m_q <= (byte_in == CH_PROMPT);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.store && !ctl.clear && !is_blank(byte_in)) begin
			stop_q <= len_q + LEN_W'(1);
			if (!nonblank_q) begin
				first_q <= len_q;
			end
		end
	end

	assign n  = stop_q - first_q;
	assign n7 = 7'(n);

	always_comb begin
		cls = CLS_LINE;
		if (n7 == 7'(OK_LEN) && ok_m_q) begin
			cls = CLS_OK;
		end else if (n7 == 7'(ERR_LEN) && err_m_q) begin
			cls = CLS_ERROR;
		end else if (n7 >= 7'(CODE_LEN) && (cme_m_q || cms_m_q)) begin
			cls = CLS_ERROR;
		end else if (n7 == 7'd1 && pr_m_q) begin
			cls = CLS_PROMPT;
		end
	end

	assign len      = len_q;
	assign first    = first_q;
	assign stop     = stop_q;
	assign nonblank = nonblank_q;

endmodule
